### src/vm_pkg.sv
// Shared types and constants for the vector magnitude block.
// No dependencies.
package vm_pkg;

	// The result field is fixed at 16 bits. A wider root saturates to the largest value.
	localparam int unsigned MAG_W = 16;

	typedef logic [MAG_W-1:0] mag_t;

	localparam mag_t MAG_MAX = '1;

endpackage

### src/vm_sq.sv
// Front of the magnitude pipeline: absolute value, squares, and their sum.
// Stand-alone module, no package dependency.
module vm_sq #(
	parameter int unsigned W = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_i,
	input  logic [W-1:0]   x_i,
	input  logic [W-1:0]   y_i,
	output logic           valid_o,
	output logic [2*W-1:0] sum_o
);

	logic           valid_s1, valid_s2, valid_s3;
	logic [W-1:0]   ax_s1, ay_s1;
	logic [2*W-1:0] xx_s2, yy_s2;
	logic [2*W-1:0] sum_s3;

	// Most negative input gives 2^(W-1), which still fits in W unsigned bits.
	function automatic logic [W-1:0] abs_w(input logic [W-1:0] v);
		abs_w = v[W-1] ? (~v + W'(1)) : v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1  <= abs_w(x_i);
		ay_s1  <= abs_w(y_i);
		xx_s2  <= (2*W)'(ax_s1) * (2*W)'(ax_s1);
		yy_s2  <= (2*W)'(ay_s1) * (2*W)'(ay_s1);
		// Sum stays below 2^(2W-1) + 1, so no carry is lost.
		sum_s3 <= xx_s2 + yy_s2;
	end

	assign valid_o = valid_s3;
	assign sum_o   = sum_s3;

endmodule

### src/vm_root_step.sv
// One digit of the restoring square root: consume two radicand bits, emit one root bit.
// Stand-alone module, no package dependency.
module vm_root_step #(
	parameter int unsigned W = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_i,
	input  logic [W:0]     rem_i,
	input  logic [W-1:0]   root_i,
	input  logic [2*W-1:0] n_i,
	output logic           valid_o,
	output logic [W:0]     rem_o,
	output logic [W-1:0]   root_o,
	output logic [2*W-1:0] n_o
);

	logic [W+2:0] acc;
	logic [W+2:0] trial;
	logic [W+2:0] diff;
	logic         take;

	always_comb begin
		acc   = {rem_i, n_i[2*W-1 -: 2]};
		trial = {1'b0, root_i, 2'b01};
		diff  = acc - trial;
		take  = (acc >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		rem_o  <= take ? diff[W:0] : acc[W:0];
		root_o <= {root_i[W-2:0], take};
		n_o    <= {n_i[2*W-3:0], 2'b00};
	end

`ifndef SYNTHESIS
	// Restoring invariant: the remainder never exceeds twice the partial root.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_o |-> ({1'b0, rem_o} <= {1'b0, root_o, 1'b0}))
		else $error("root step remainder above twice the partial root");
`endif

endmodule

### src/vector_magnitude.sv
// Top level of the vector magnitude block: floor(sqrt(x*x + y*y)), saturated to 16 bits.
// Depends on vm_pkg, vm_sq and vm_root_step.
//
//  channel  | ports                           | handshake
//  ---------+---------------------------------+-----------------------------------
//  request  | start, x_component, y_component | taken at an edge with start && !busy
//  result   | done, magnitude                 | one-cycle strobe, never held off
//
// One request enters every cycle; busy is always low since nothing can back up.
// The pipeline registers absolute values, then squares, then their sum, then one
// root bit per step in the digit chain, and finally the saturated result in the
// output register.
// Reset clears only the valid bits; payload registers carry no reset.
// The receiver cannot stall, so the pipeline advances on every clock.
module vector_magnitude
	import vm_pkg::*;
#(
	parameter int unsigned COMPONENT_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [COMPONENT_WIDTH-1:0] x_component,
	input  logic [COMPONENT_WIDTH-1:0] y_component,
	output logic                       done,
	output mag_t                       magnitude
);

	localparam int unsigned W     = COMPONENT_WIDTH;
	localparam int unsigned EXT_W = (W > MAG_W) ? W : MAG_W;
	localparam int unsigned LAT   = W + 4;

	logic           sq_valid;
	logic [2*W-1:0] sq_sum;

	// Root chain taps: entry k feeds digit k, entry W is the finished root.
	logic           valid_c [0:W];
	logic [W:0]     rem_c   [0:W];
	logic [W-1:0]   root_c  [0:W];
	logic [2*W-1:0] n_c     [0:W];

	logic [EXT_W-1:0] root_ext;
	mag_t             mag_sat;
	logic             done_q;
	mag_t             magnitude_q;

	// Accept a request whenever start is high.
	vm_sq #(.W(W)) u_sq (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (start),
		.x_i     (x_component),
		.y_i     (y_component),
		.valid_o (sq_valid),
		.sum_o   (sq_sum)
	);

	// Seed the digit chain with an empty remainder and root.
	assign valid_c[0] = sq_valid;
	assign rem_c[0]   = '0;
	assign root_c[0]  = '0;
	assign n_c[0]     = sq_sum;

	// Advance one root bit per stage, most significant first.
	for (genvar k = 0; k < W; k++) begin : g_root
		vm_root_step #(.W(W)) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (valid_c[k]),
			.rem_i   (rem_c[k]),
			.root_i  (root_c[k]),
			.n_i     (n_c[k]),
			.valid_o (valid_c[k+1]),
			.rem_o   (rem_c[k+1]),
			.root_o  (root_c[k+1]),
			.n_o     (n_c[k+1])
		);
	end

	// Clamp roots above the 16-bit range instead of wrapping them.
	always_comb begin
		root_ext = EXT_W'(root_c[W]);
		mag_sat  = (root_ext > EXT_W'(MAG_MAX)) ? MAG_MAX : root_ext[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_c[W];
		end
	end

	always_ff @(posedge clk) begin
		magnitude_q <= mag_sat;
	end

	assign busy      = 1'b0;
	assign done      = done_q;
	assign magnitude = magnitude_q;

`ifndef SYNTHESIS
	// Every result traces back to an accepted request.
	a_done_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a matching request");

	// Every accepted request yields a result.
	a_req_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("request dropped in the pipeline");

	// A zero vector comes out as zero.
	a_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (x_component == '0) && (y_component == '0))
			|-> ##LAT (magnitude == '0))
		else $error("zero vector gave a nonzero magnitude");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for vector_magnitude: floor(sqrt(x*x + y*y)) at the default width.
// Depends on vm_pkg and the vector_magnitude RTL; an in-bench predictor supplies expected values.
`timescale 1ns / 1ps
module tb_top
	import vm_pkg::*;
();

	localparam int unsigned CW = 16;
	// Pipeline depth given by the block's top level.
	localparam int unsigned LATENCY = CW + 4;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam logic [CW-1:0] COMP_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [CW-1:0] COMP_MAX = ~COMP_MIN;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	logic [CW-1:0] x_component = '0;
	logic [CW-1:0] y_component = '0;
	logic          done;
	mag_t          magnitude;

	// Expected magnitudes, oldest first.
	mag_t        expected_mags[$];
	int unsigned cycle_count = 0;
	int unsigned requests_sent = 0;
	int unsigned results_checked = 0;
	int unsigned error_count = 0;

	vector_magnitude #(
		.COMPONENT_WIDTH(CW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.x_component(x_component),
		.y_component(y_component),
		.done(done),
		.magnitude(magnitude)
	);

	always #1 clk = ~clk;

	// Give up on a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results still pending",
				$time, cycle_count, expected_mags.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Floor of the exact Euclidean length, saturated to the result width.
	function automatic mag_t predict_magnitude(logic [CW-1:0] xv, logic [CW-1:0] yv);
		longint unsigned ax;
		longint unsigned ay;
		longint unsigned sum_sq;
		longint unsigned root;
		longint unsigned trial;
		// Two's complement magnitude within CW bits; the most negative value stays exact.
		ax = xv[CW-1] ? (64'd1 << CW) - 64'(xv) : 64'(xv);
		ay = yv[CW-1] ? (64'd1 << CW) - 64'(yv) : 64'(yv);
		sum_sq = ax * ax + ay * ay;
		// Build the root one bit at a time from the top, keeping a bit when its square fits.
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= sum_sq)
				root = trial;
		end
		if (root > 64'(MAG_MAX))
			return MAG_MAX;
		return mag_t'(root);
	endfunction

	// Present one request and hold it until the block takes it.
	task automatic send_vector(input logic [CW-1:0] xv, input logic [CW-1:0] yv);
		start <= 1'b1;
		x_component <= xv;
		y_component <= yv;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		expected_mags.push_back(predict_magnitude(xv, yv));
		requests_sent++;
	endtask

	// Drop start for each cycle that draws an idle, with junk on the payload, which must be
	// ignored; idle_pct is the share of cycles left idle.
	task automatic maybe_idle(input int unsigned idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			x_component <= CW'($urandom());
			y_component <= CW'($urandom());
			@(posedge clk);
		end
	endtask

	// Draw one vector: mostly full range, with small, corner, on-axis and exact-length mixes.
	task automatic make_vector(output logic [CW-1:0] xv, output logic [CW-1:0] yv);
		logic [CW-1:0] corners[6];
		int unsigned   k;
		corners = '{COMP_MIN, COMP_MIN + 1'b1, '1, '0, CW'(1), COMP_MAX};
		case ($urandom_range(0, 9))
			5, 6: begin
				xv = CW'($urandom_range(0, 32));
				xv = xv - CW'(16);
				yv = CW'($urandom_range(0, 32));
				yv = yv - CW'(16);
			end
			7: begin
				xv = corners[$urandom_range(0, 5)];
				yv = corners[$urandom_range(0, 5)];
			end
			8: begin
				xv = CW'($urandom());
				yv = '0;
				if ($urandom_range(0, 1))
					{xv, yv} = {yv, xv};
			end
			9: begin
				// Scaled 3-4-5 and 5-12-13 triangles land exactly on an integer root.
				if ($urandom_range(0, 1)) begin
					k = $urandom_range(1, 8191);
					xv = CW'(3 * k);
					yv = CW'(4 * k);
				end else begin
					k = $urandom_range(1, 2730);
					xv = CW'(5 * k);
					yv = CW'(12 * k);
				end
				if ($urandom_range(0, 1))
					xv = -xv;
				if ($urandom_range(0, 1))
					yv = -yv;
			end
			default: begin
				xv = CW'($urandom());
				yv = CW'($urandom());
			end
		endcase
	endtask

	task automatic run_random(input int unsigned count, input int unsigned idle_pct);
		logic [CW-1:0] xv;
		logic [CW-1:0] yv;
		repeat (count) begin
			make_vector(xv, yv);
			send_vector(xv, yv);
			maybe_idle(idle_pct);
		end
	endtask

	// Zero, axes, sign and range corners, exact triangles and alternating bit patterns.
	task automatic test_directed_cases();
		send_vector('0, '0);
		send_vector(COMP_MIN, COMP_MIN);
		send_vector(COMP_MAX, COMP_MAX);
		send_vector(COMP_MAX, COMP_MIN);
		send_vector(COMP_MIN, '0);
		send_vector('0, COMP_MIN);
		send_vector(COMP_MAX, '0);
		send_vector('0, COMP_MAX);
		send_vector(CW'(1), '0);
		send_vector('1, '1);
		send_vector(CW'(1), CW'(1));
		send_vector(CW'(3), CW'(4));
		send_vector(-16'sd5, 16'd12);
		send_vector(-16'sd3000, -16'sd4000);
		send_vector(16'h5555, 16'hAAAA);
		send_vector(16'hAAAA, 16'h5555);
		send_vector(COMP_MIN + 1'b1, COMP_MIN + 1'b1);
		send_vector(16'd24576, 16'd32767);
		send_vector(16'd2, 16'd2);
		send_vector(16'd181, 16'd0);
		start <= 1'b0;
		repeat (3) @(posedge clk);
	endtask

	task automatic test_random_light_gaps();
		run_random(400, 28);
	endtask

	task automatic test_random_heavy_gaps();
		run_random(400, 77);
	endtask

	task automatic test_random_back_to_back();
		run_random(400, 0);
	endtask

	// Compare each result with the oldest expectation; results are never held off.
	always @(posedge clk) begin
		if (arst_n) begin
			if ($isunknown(done)) begin
				$display("%0t: done is unknown", $time);
				error_count++;
			end else if (done) begin
				if (expected_mags.size() == 0) begin
					$display("%0t: unexpected result, expected none, got magnitude %0d",
						$time, magnitude);
					error_count++;
				end else begin
					if (magnitude !== expected_mags[0]) begin
						$display("%0t: magnitude mismatch, expected %0d, got %0d",
							$time, expected_mags[0], magnitude);
						error_count++;
					end
					void'(expected_mags.pop_front());
					results_checked++;
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_random_light_gaps();
		test_random_heavy_gaps();
		test_random_back_to_back();
		start <= 1'b0;

		// Drain the pipeline, then watch for stray strobes.
		while (expected_mags.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);

		$display("Sent %0d vectors (corners, exact triangles, full range) under three gap mixes;",
			requests_sent);
		$display("checked %0d magnitudes in %0d cycles.", results_checked, cycle_count);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
